>>> design/gbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_pkg
// Shared constants and types for the grid bin locator.
// ----------------------------------------------------------------------------
package gbl_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int BIN_BITS_DEF    = 10;
  localparam int CFG_ADDR_W      = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENT_X   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENT_Y   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENT_Z   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BIN_COUNTS = 3'd6;

  // command codes
  localparam logic CMD_LOCATE    = 1'b0;
  localparam logic CMD_NEIGHBOUR = 1'b1;

  // control bits carried with a located point
  typedef struct packed {
    logic outside;
    logic cmd;
  } gbl_ctl_t;

endpackage

>>> design/gbl_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_locate
// Pipelined bin locator: offset/range check, product, restoring division.
// ----------------------------------------------------------------------------
module gbl_locate import gbl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int BIN_BITS    = BIN_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pt_valid,
  output logic                     pt_ready,
  input  logic                     pt_cmd,
  input  logic [COORD_WIDTH-1:0]   pt_x,
  input  logic [COORD_WIDTH-1:0]   pt_y,
  input  logic [COORD_WIDTH-1:0]   pt_z,
  input  logic [COORD_WIDTH-1:0]   origin_x,
  input  logic [COORD_WIDTH-1:0]   origin_y,
  input  logic [COORD_WIDTH-1:0]   origin_z,
  input  logic [COORD_WIDTH-1:0]   extent_x,
  input  logic [COORD_WIDTH-1:0]   extent_y,
  input  logic [COORD_WIDTH-1:0]   extent_z,
  input  logic [3*BIN_BITS-1:0]    bin_counts,
  output logic                     loc_valid,
  input  logic                     loc_ready,
  output gbl_ctl_t                 loc_ctl,
  output logic [BIN_BITS-1:0]      loc_bin_x,
  output logic [BIN_BITS-1:0]      loc_bin_y,
  output logic [BIN_BITS-1:0]      loc_bin_z
);

  localparam int C  = COORD_WIDTH;
  localparam int B  = BIN_BITS;
  localparam int W  = C + B + 7;   // holds 99*n*d and 100*e << (B-1)
  localparam int NW = B + 7;       // holds 99*n

  logic [C-1:0] pt_a [0:2];
  logic [C-1:0] org_a [0:2];
  logic [C-1:0] ext_a [0:2];
  logic [W-1:0] div_a [0:2];
  logic [NW-1:0] n99_a [0:2];
  logic [2:0]   axis_out;
  logic [2:0]   axis_zero;
  logic [C-1:0] diff_a [0:2];
  logic         adv;

  assign pt_a[0]  = pt_x;
  assign pt_a[1]  = pt_y;
  assign pt_a[2]  = pt_z;
  assign org_a[0] = origin_x;
  assign org_a[1] = origin_y;
  assign org_a[2] = origin_z;
  assign ext_a[0] = extent_x;
  assign ext_a[1] = extent_y;
  assign ext_a[2] = extent_z;

  // whole pipe moves together; held only when the last stage is blocked
  assign adv      = !loc_valid || loc_ready;
  assign pt_ready = adv;

  // stage 1 registers
  logic         v1_r;
  gbl_ctl_t     ctl1_r;
  logic [2:0]   z1_r;
  logic [C-1:0] d1_r [0:2];

  // stage 2 and division stages: index 0 is the product stage
  logic         pv_r   [0:B];
  gbl_ctl_t     pctl_r [0:B];
  logic [2:0]   pz_r   [0:B];
  logic [W-1:0] prem_r [0:B][0:2];
  logic [B-1:0] pq_r   [0:B][0:2];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [C-1:0] uq, um;
    logic [B-1:0] n_raw;
    assign uq    = pt_a[a]  ^ {1'b1, {(C-1){1'b0}}};
    assign um    = org_a[a] ^ {1'b1, {(C-1){1'b0}}};
    assign n_raw = bin_counts[a*B +: B];
    assign diff_a[a]    = uq - um;
    assign axis_zero[a] = (ext_a[a] == '0);
    assign axis_out[a]  = !axis_zero[a] && ((uq < um) || (diff_a[a] > ext_a[a]));
    // 99*n (count of zero reads as one) and 100*e
    assign n99_a[a] = NW'(n_raw == '0 ? B'(1) : n_raw) * NW'(99);
    assign div_a[a] = W'(ext_a[a]) * W'(100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1_r.cmd     <= pt_cmd;
      ctl1_r.outside <= |axis_out;
      z1_r           <= axis_zero;
      for (int a = 0; a < 3; a++) begin
        d1_r[a] <= diff_a[a];
      end
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else if (adv) begin
      pv_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pctl_r[0] <= ctl1_r;
      pz_r[0]   <= z1_r;
      for (int a = 0; a < 3; a++) begin
        prem_r[0][a] <= W'(n99_a[a]) * W'(d1_r[a]);
        pq_r[0][a]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 1; j <= B; j++) begin : g_div
    localparam int K = B - j;
    logic [W-1:0] sub  [0:2];
    logic [2:0]   take;
    for (genvar a = 0; a < 3; a++) begin : g_ax
      assign sub[a]  = div_a[a] << K;
      assign take[a] = (prem_r[j-1][a] >= sub[a]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[j] <= 1'b0;
      end else if (adv) begin
        pv_r[j] <= pv_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pctl_r[j] <= pctl_r[j-1];
        pz_r[j]   <= pz_r[j-1];
        for (int a = 0; a < 3; a++) begin
          prem_r[j][a] <= take[a] ? prem_r[j-1][a] - sub[a] : prem_r[j-1][a];
          pq_r[j][a]   <= pq_r[j-1][a] | (B'(take[a]) << K);
        end
      end
    end
  end

  assign loc_valid = pv_r[B];
  assign loc_ctl   = pctl_r[B];
  assign loc_bin_x = (pz_r[B][0] || pctl_r[B].outside) ? '0 : pq_r[B][0];
  assign loc_bin_y = (pz_r[B][1] || pctl_r[B].outside) ? '0 : pq_r[B][1];
  assign loc_bin_z = (pz_r[B][2] || pctl_r[B].outside) ? '0 : pq_r[B][2];

endmodule

>>> design/gbl_nbr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_nbr
// Neighbour sequencer: walks one bin or the clamped 3x3x3 block to a register.
// ----------------------------------------------------------------------------
module gbl_nbr import gbl_pkg::*; #(
  parameter int BIN_BITS = BIN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [3*BIN_BITS-1:0] bin_counts,
  input  logic                  loc_valid,
  output logic                  loc_ready,
  input  gbl_ctl_t              loc_ctl,
  input  logic [BIN_BITS-1:0]   loc_bin_x,
  input  logic [BIN_BITS-1:0]   loc_bin_y,
  input  logic [BIN_BITS-1:0]   loc_bin_z,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_outside,
  output logic [BIN_BITS-1:0]   res_x,
  output logic [BIN_BITS-1:0]   res_y,
  output logic [BIN_BITS-1:0]   res_z,
  output logic                  res_last
);

  localparam int B = BIN_BITS;

  logic [B-1:0] bin_a [0:2];
  logic [B-1:0] lo_nxt [0:2];
  logic [B-1:0] hi_nxt [0:2];

  logic         busy_r;
  logic         oflag_r;
  logic [B-1:0] cur_r [0:2];
  logic [B-1:0] lo_r  [0:2];
  logic [B-1:0] hi_r  [0:2];
  logic         res_valid_r;
  logic         res_outside_r;
  logic [B-1:0] res_x_r, res_y_r, res_z_r;
  logic         res_last_r;

  logic emit, last_now, load;

  assign bin_a[0] = loc_bin_x;
  assign bin_a[1] = loc_bin_y;
  assign bin_a[2] = loc_bin_z;

  for (genvar a = 0; a < 3; a++) begin : g_rng
    logic [B-1:0] n_raw, n_top;
    logic [B:0]   up;
    logic         single;
    assign n_raw  = bin_counts[a*B +: B];
    assign n_top  = (n_raw == '0) ? '0 : n_raw - B'(1);
    assign up     = {1'b0, bin_a[a]} + (B+1)'(1);
    assign single = loc_ctl.outside || (loc_ctl.cmd == CMD_LOCATE);
    assign lo_nxt[a] = (single || bin_a[a] == '0) ? bin_a[a] : bin_a[a] - B'(1);
    assign hi_nxt[a] = single ? bin_a[a] :
                       (up > {1'b0, n_top}) ? n_top : up[B-1:0];
  end

  assign emit     = busy_r && (!res_valid_r || res_ready);
  assign last_now = (cur_r[0] == hi_r[0]) && (cur_r[1] == hi_r[1]) && (cur_r[2] == hi_r[2]);
  assign loc_ready = !busy_r || (emit && last_now);
  assign load     = loc_valid && loc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && last_now) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_outside_r <= oflag_r;
      res_x_r       <= cur_r[0];
      res_y_r       <= cur_r[1];
      res_z_r       <= cur_r[2];
      res_last_r    <= last_now;
    end
    if (load) begin
      oflag_r <= loc_ctl.outside;
      for (int a = 0; a < 3; a++) begin
        lo_r[a]  <= lo_nxt[a];
        hi_r[a]  <= hi_nxt[a];
        cur_r[a] <= lo_nxt[a];
      end
    end else if (emit && !last_now) begin
      // z innermost, x outermost
      if (cur_r[2] != hi_r[2]) begin
        cur_r[2] <= cur_r[2] + B'(1);
      end else begin
        cur_r[2] <= lo_r[2];
        if (cur_r[1] != hi_r[1]) begin
          cur_r[1] <= cur_r[1] + B'(1);
        end else begin
          cur_r[1] <= lo_r[1];
          cur_r[0] <= cur_r[0] + B'(1);
        end
      end
    end
  end

  assign res_valid   = res_valid_r;
  assign res_outside = res_outside_r;
  assign res_x       = res_x_r;
  assign res_y       = res_y_r;
  assign res_z       = res_z_r;
  assign res_last    = res_last_r;

endmodule

>>> design/grid_bin_locate_and_neighbours.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bin_locate_and_neighbours
// Uniform 3D grid: bin of a Q16.16 point, or its clamped neighbour block.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one transfer per query point; in_tuser is the command (0 own bin,
//           1 neighbours), in_tdata holds point x, y, z.
//   out_* : one transfer per result; out_tuser flags a point outside the box
//           (bins zero), out_tlast marks the final result of a query.
//   cfg_* : register writes, taken at once; write only while the block is idle.
// Path: the capture stage loads on the input transfer edge itself; the point
//   then passes the product stage, one stage per quotient bit, the sequencer
//   and the output register before its first result is offered.
// Throughput: the locator takes a point every cycle while its last stage is
//   not blocked; the sequencer emits one result per cycle while the output
//   register is free, so a query of up to 27 results holds the input longer.
// Reset: synchronous, clears all valid bits and restores the register defaults
//   (origins and extents zero, one bin per axis).
// Stall: while out_tready is low the result register holds; the locator pipe
//   fills and then drops in_tready. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module grid_bin_locate_and_neighbours import gbl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int BIN_BITS    = BIN_BITS_DEF,
  localparam int CFG_W      = (COORD_WIDTH > 3*BIN_BITS) ? COORD_WIDTH : 3*BIN_BITS,
  localparam int IN_TW      = ((3*COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW     = ((3*BIN_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,   // point_x, point_y, point_z, pad
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TW-1:0]     out_tdata,  // bin_x, bin_y, bin_z, pad
  output logic                  out_tuser,  // outside
  output logic                  out_tlast,  // last
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int C = COORD_WIDTH;
  localparam int B = BIN_BITS;

  logic [C-1:0]   origin_r [0:2];
  logic [C-1:0]   extent_r [0:2];
  logic [3*B-1:0] bin_counts_r;

  // registers; bins default to one per axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        origin_r[a] <= '0;
        extent_r[a] <= '0;
      end
      bin_counts_r <= {3{{(B-1){1'b0}}, 1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X:   origin_r[0]  <= cfg_wdata[C-1:0];
        REG_ORIGIN_Y:   origin_r[1]  <= cfg_wdata[C-1:0];
        REG_ORIGIN_Z:   origin_r[2]  <= cfg_wdata[C-1:0];
        REG_EXTENT_X:   extent_r[0]  <= cfg_wdata[C-1:0];
        REG_EXTENT_Y:   extent_r[1]  <= cfg_wdata[C-1:0];
        REG_EXTENT_Z:   extent_r[2]  <= cfg_wdata[C-1:0];
        REG_BIN_COUNTS: bin_counts_r <= cfg_wdata[3*B-1:0];
        default: ;
      endcase
    end
  end

  gbl_ctl_t     loc_ctl;
  logic         loc_valid, loc_ready;
  logic [B-1:0] loc_bin_x, loc_bin_y, loc_bin_z;
  logic [B-1:0] res_x, res_y, res_z;

  gbl_locate #(
    .COORD_WIDTH (COORD_WIDTH),
    .BIN_BITS    (BIN_BITS)
  ) u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (in_tvalid),
    .pt_ready   (in_tready),
    .pt_cmd     (in_tuser),
    .pt_x       (in_tdata[C-1:0]),
    .pt_y       (in_tdata[2*C-1:C]),
    .pt_z       (in_tdata[3*C-1:2*C]),
    .origin_x   (origin_r[0]),
    .origin_y   (origin_r[1]),
    .origin_z   (origin_r[2]),
    .extent_x   (extent_r[0]),
    .extent_y   (extent_r[1]),
    .extent_z   (extent_r[2]),
    .bin_counts (bin_counts_r),
    .loc_valid  (loc_valid),
    .loc_ready  (loc_ready),
    .loc_ctl    (loc_ctl),
    .loc_bin_x  (loc_bin_x),
    .loc_bin_y  (loc_bin_y),
    .loc_bin_z  (loc_bin_z)
  );

  gbl_nbr #(
    .BIN_BITS (BIN_BITS)
  ) u_nbr (
    .clk         (clk),
    .rst_n       (rst_n),
    .bin_counts  (bin_counts_r),
    .loc_valid   (loc_valid),
    .loc_ready   (loc_ready),
    .loc_ctl     (loc_ctl),
    .loc_bin_x   (loc_bin_x),
    .loc_bin_y   (loc_bin_y),
    .loc_bin_z   (loc_bin_z),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_outside (out_tuser),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_z       (res_z),
    .res_last    (out_tlast)
  );

  assign out_tdata = OUT_TW'({res_z, res_y, res_x});

`ifndef ASSERT_OFF
  // an outside result is a lone, zeroed transfer
  a_outside_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && res_x == '0 && res_y == '0 && res_z == '0)
    else $error("outside result not single or not zeroed");

  // a located point waits in the pipe until the sequencer takes it
  a_loc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    loc_valid && !loc_ready |=> loc_valid)
    else $error("located point dropped while sequencer busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
`endif

endmodule

>>> tb/sv/grid_bin_locate_and_neighbours_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bin_locate_and_neighbours_tb
// Self-checking bench for the 3D grid bin locator.
// Drives query points through the input stream, predicts every bin or
// neighbour block with exact integer arithmetic, and checks each result
// transfer in order. Register settings change between phases, only while
// the block is idle. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module grid_bin_locate_and_neighbours_tb;
  import gbl_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int BB      = BIN_BITS_DEF;
  localparam int CFG_W   = (CW > 3*BB) ? CW : 3*BB;
  localparam int IN_TW   = ((3*CW + 7) / 8) * 8;
  localparam int OUT_TW  = ((3*BB + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = BB + 20;   // block latency plus margin
  localparam int STALL_LIMIT  = 4000;      // cycles with no transfer at all

  typedef struct packed {
    logic          outside;
    logic [BB-1:0] bx;
    logic [BB-1:0] by;
    logic [BB-1:0] bz;
    logic          last;
  } bin_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;   // point_x, point_y, point_z
  logic in_tuser = 1'b0;             // cmd
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;      // bin_x, bin_y, bin_z, pad
  logic out_tuser;                   // outside
  logic out_tlast;                   // last
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  grid_bin_locate_and_neighbours DUT (.*);

  // shadow copy of the grid registers
  logic [CW-1:0]   grid_org [3];
  logic [CW-1:0]   grid_ext [3];
  logic [3*BB-1:0] grid_bins;

  bin_res_t bins_due[$];
  int       mismatches = 0;
  int       quiet_cnt = 0;     // >0: no idling on either side
  int       stall_cnt = 0;

  initial forever #5 clk = ~clk;

  // result side back-pressure
  always @(negedge clk)
    out_tready <= (quiet_cnt > 0) ? 1'b1 : ($urandom_range(99) >= 9);

  // result checker: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    bin_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[BB-1:0], out_tdata[2*BB-1:BB],
              out_tdata[3*BB-1:2*BB], out_tlast};
      if (bins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = bins_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint unsigned axis_bins(int a);
    longint unsigned n = (grid_bins >> (BB*a)) & ((1 << BB) - 1);
    return (n == 0) ? 1 : n;
  endfunction

  // append one expected result to the tail of the queue
  task automatic queue_result(bin_res_t r);
    bins_due.insert(bins_due.size(), r);
  endtask

  // Expected results for one query point; exact floor of 99*n*d / (100*e).
  task automatic predict_bins(logic cmd, logic [CW-1:0] pt [3]);
    longint unsigned uq, um, e, n;
    longint unsigned b [3], lo [3], hi [3];
    logic out_box = 1'b0;
    int total, cnt = 0;
    for (int a = 0; a < 3; a++) begin
      uq = pt[a] ^ (64'd1 << (CW-1));
      um = grid_org[a] ^ (64'd1 << (CW-1));
      e  = grid_ext[a];
      b[a] = 0;
      if (e != 0) begin
        if (uq < um || uq - um > e) out_box = 1'b1;
        else b[a] = (99 * axis_bins(a) * (uq - um)) / (100 * e);
      end
    end
    if (out_box) begin
      queue_result('{1'b1, '0, '0, '0, 1'b1});
      return;
    end
    if (cmd == CMD_LOCATE) begin
      queue_result('{1'b0, b[0][BB-1:0], b[1][BB-1:0], b[2][BB-1:0], 1'b1});
      return;
    end
    for (int a = 0; a < 3; a++) begin
      n = axis_bins(a);
      lo[a] = (b[a] == 0) ? 0 : b[a] - 1;
      hi[a] = (b[a] + 1 > n - 1) ? n - 1 : b[a] + 1;
    end
    total = (hi[0]-lo[0]+1) * (hi[1]-lo[1]+1) * (hi[2]-lo[2]+1);
    for (longint unsigned i = lo[0]; i <= hi[0]; i++)
      for (longint unsigned j = lo[1]; j <= hi[1]; j++)
        for (longint unsigned k = lo[2]; k <= hi[2]; k++) begin
          cnt++;
          queue_result('{1'b0, i[BB-1:0], j[BB-1:0], k[BB-1:0], cnt == total});
        end
  endtask

  // one query transfer; valid is left high so back-to-back items stay seamless
  task automatic send_point(logic cmd, logic [CW-1:0] x, logic [CW-1:0] y,
                            logic [CW-1:0] z);
    logic [CW-1:0] pt [3];
    pt = '{x, y, z};
    if (quiet_cnt == 0 && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TW'({z, y, x});
    do @(posedge clk); while (!in_tready);
    predict_bins(cmd, pt);
    if (quiet_cnt > 0) quiet_cnt--;
    @(negedge clk);
  endtask

  // sender holds off until every expected result has arrived
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // drives one write for a cycle; the caller drops cfg_we after the last one
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      REG_ORIGIN_X: grid_org[0] = val[CW-1:0];
      REG_ORIGIN_Y: grid_org[1] = val[CW-1:0];
      REG_ORIGIN_Z: grid_org[2] = val[CW-1:0];
      REG_EXTENT_X: grid_ext[0] = val[CW-1:0];
      REG_EXTENT_Y: grid_ext[1] = val[CW-1:0];
      REG_EXTENT_Z: grid_ext[2] = val[CW-1:0];
      REG_BIN_COUNTS: grid_bins = val[3*BB-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [CW-1:0] ox, oy, oz, ex, ey, ez,
                          logic [BB-1:0] nx, ny, nz);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_EXTENT_X, ex);
    write_reg(REG_EXTENT_Y, ey);
    write_reg(REG_EXTENT_Z, ez);
    write_reg(REG_BIN_COUNTS, CFG_W'({nz, ny, nx}));
    cfg_we <= 1'b0;
  endtask

  // coordinate on one axis: mostly inside the box, sometimes anywhere
  function automatic logic [CW-1:0] pick_coord(int a);
    longint unsigned um, r, lim;
    lim = 64'hFFFF_FFFF;
    if ($urandom_range(99) < 12) return $urandom;
    um = grid_org[a] ^ (64'd1 << (CW-1));
    case ($urandom_range(9))
      0: r = 0;
      1: r = grid_ext[a];
      default: r = {$urandom, $urandom} % (longint'(grid_ext[a]) + 1);
    endcase
    r = um + r;
    if (r > lim) r = lim;
    return r[CW-1:0] ^ (1 << (CW-1));
  endfunction

  // reset defaults: all axes degenerate, one bin each
  task automatic test_reset_defaults();
    send_point(CMD_LOCATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_point(CMD_NEIGHBOUR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
  endtask

  // box edges, outside below and above, degenerate axis, zero bin count
  task automatic test_directed();
    // box [-1.0, +1.0] on x,y; z degenerate; bin counts 10, 0 (=1), 1023
    set_grid(32'hFFFF_0000, 32'hFFFF_0000, 32'h1234_5678,
             32'h0002_0000, 32'h0002_0000, 32'h0, 10'd10, 10'd0, 10'd1023);
    send_point(CMD_LOCATE,    32'hFFFF_0000, 32'hFFFF_0000, 32'h8000_0000);
    send_point(CMD_LOCATE,    32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    send_point(CMD_NEIGHBOUR, 32'h0000_0000, 32'h0000_0000, 32'h0);
    send_point(CMD_NEIGHBOUR, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    send_point(CMD_LOCATE,    32'hFFFE_FFFF, 32'h0, 32'h0);  // just below x
    send_point(CMD_NEIGHBOUR, 32'h0, 32'h0001_0001, 32'h0);  // just above y
    send_point(CMD_NEIGHBOUR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    // widest box, largest counts: full signed range on every axis
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             10'd1023, 10'd1023, 10'd1023);
    send_point(CMD_LOCATE,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(CMD_LOCATE,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(CMD_NEIGHBOUR, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    send_point(CMD_NEIGHBOUR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
    // top origin, tiny extent, two bins
    set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h0,
             32'h0, 32'h1, 32'h1, 10'd2, 10'd2, 10'd2);
    send_point(CMD_NEIGHBOUR, 32'h0, 32'h7FFF_FFFF, 32'h1);
    send_point(CMD_LOCATE,    32'h0, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
  endtask

  // random grids with random points; one phase with no idling at all
  task automatic test_random_points();
    for (int ph = 0; ph < 12; ph++) begin
      set_grid($urandom, $urandom, $urandom,
               ($urandom_range(5) == 0) ? 32'h0 : $urandom >> $urandom_range(31),
               ($urandom_range(5) == 0) ? 32'h0 : $urandom >> $urandom_range(31),
               ($urandom_range(5) == 0) ? 32'h0 : $urandom >> $urandom_range(31),
               (ph % 4 == 3) ? 10'($urandom) : 10'($urandom_range(0, 6)),
               (ph % 4 == 3) ? 10'($urandom) : 10'($urandom_range(0, 6)),
               (ph % 4 == 3) ? 10'($urandom) : 10'($urandom_range(0, 6)));
      if (ph == 5) quiet_cnt = 40;
      repeat (38) send_point(1'($urandom_range(1)), pick_coord(0), pick_coord(1),
                             pick_coord(2));
    end
  endtask

  initial begin
    grid_org  = '{default: '0};
    grid_ext  = '{default: '0};
    grid_bins = {10'd1, 10'd1, 10'd1};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed();
    test_random_points();
    wait_idle();
    if (mismatches == 0 && bins_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/gbl_pkg.sv
design/gbl_locate.sv
design/gbl_nbr.sv
design/grid_bin_locate_and_neighbours.sv
tb/sv/grid_bin_locate_and_neighbours_tb.sv
